// ----- src/utf8_char_splitter_assert.svh -----
// Assertion macros shared by the UTF-8 character splitter RTL.
`ifndef UTF8_CHAR_SPLITTER_ASSERT_SVH
`define UTF8_CHAR_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define UCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define UCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ucs_pkg.sv -----
// Constants and helper types for the UTF-8 character splitter.
`timescale 1ns / 1ps

package ucs_pkg;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] NUL_BYTE     = 8'd0;
	localparam logic [7:0] LEAD4_MIN    = 8'd240;
	localparam logic [7:0] LEAD3_MIN    = 8'd224;
	localparam logic [7:0] LEAD2_MIN    = 8'd192;
	localparam logic [7:0] CONT_MIN     = 8'd128;

	// Character lengths in bytes.
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_1    = 3'd1;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	// One completed character as it leaves the decode logic.
	typedef struct packed {
		logic        valid;
		logic [31:0] bytes;
		logic [2:0]  length;
	} char_result_t;

	// True for a continuation byte (10xxxxxx).
	function automatic logic is_cont(input logic [7:0] b);
		return (b >= CONT_MIN) && (b < LEAD2_MIN);
	endfunction

endpackage

// ----- src/utf8_char_splitter.sv -----
// Top level of the UTF-8 character splitter: byte input register, decode, result register.
`timescale 1ns / 1ps

// The splitter takes a text stream one word (one byte) per clock and emits each
// completed UTF-8 character as one output word: the bytes packed from bit 31
// downward with the unused low bytes zero, and the length in bytes (1 to 4).
// A lead byte of 240 and above opens a four-byte character, 224 to 239 a
// three-byte one, 192 to 223 a two-byte one, and 1 to 127 is a complete
// single-byte character, the newline included. A continuation byte found where
// a lead byte is expected is skipped. A NUL lead byte, or a byte that should
// have been a continuation but is not, throws the partial character away and
// discards the rest of the line up to and including the next newline; when the
// offending byte is itself a newline, the line simply ends there and nothing is
// emitted for it. Rate: one byte is accepted every clock, save while a stall
// holds the input as described below. Each byte is held in the input
// register, is decoded against the collection state by a single layer of
// compare and select logic, and a finished character is then written into
// the output register, which presents it on the output until it is taken.
// The input side keeps flowing while a finished character waits to be taken,
// as long as the bytes arriving produce no new character; only a second
// finished character stalls the input.
module utf8_char_splitter
	import ucs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] char_bytes,
	output logic [2:0]  char_length
);

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  data_s1;

	// Collection state.
	logic [1:0]  bytes_needed_q;
	logic [23:0] partial_char_q;
	logic [2:0]  char_total_q;
	logic        dropping_q;

	// Result register.
	logic        out_valid_q;
	logic [31:0] char_bytes_q;
	logic [2:0]  char_length_q;

	// Decode outputs.
	char_result_t res;
	logic [1:0]  bytes_needed_d;
	logic [23:0] partial_char_d;
	logic [2:0]  char_total_d;
	logic        dropping_d;
	logic [31:0] acc;
	logic        s1_go;

	// The word in the input register may move on unless it completes a character
	// while the result register is still holding one that has not been taken.
	assign s1_go    = valid_s1 && (!res.valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	// Continuation appended to the bytes collected so far.
	assign acc = {partial_char_q, data_s1};

	always_comb begin
		res            = '0;
		bytes_needed_d = bytes_needed_q;
		partial_char_d = partial_char_q;
		char_total_d   = char_total_q;
		dropping_d     = dropping_q;

		priority if (dropping_q) begin
			// Skip everything up to and including the newline.
			if (data_s1 == NEWLINE_BYTE) begin
				dropping_d = 1'b0;
			end
		end else if (bytes_needed_q != 2'd0) begin
			if (is_cont(data_s1)) begin
				bytes_needed_d = bytes_needed_q - 2'd1;
				if (bytes_needed_q != 2'd1) begin
					partial_char_d = acc[23:0];
				end else begin
					// Last byte: left-align the character in the word.
					res.valid = 1'b1;
					unique case (char_total_q)
						LEN_4: begin
							res.bytes  = acc;
							res.length = LEN_4;
						end
						LEN_3: begin
							res.bytes  = {acc[23:0], 8'd0};
							res.length = LEN_3;
						end
						LEN_2: begin
							res.bytes  = {acc[15:0], 16'd0};
							res.length = LEN_2;
						end
						default: begin
							res.bytes  = {acc[7:0], 24'd0};
							res.length = LEN_1;
						end
					endcase
					partial_char_d = '0;
					char_total_d   = LEN_NONE;
				end
			end else begin
				// Broken sequence: a newline just ends the line, anything else
				// discards the rest of it.
				bytes_needed_d = 2'd0;
				partial_char_d = '0;
				char_total_d   = LEN_NONE;
				dropping_d     = (data_s1 != NEWLINE_BYTE);
			end
		end else if (data_s1 == NUL_BYTE) begin
			dropping_d = 1'b1;
		end else if (data_s1 >= LEAD4_MIN) begin
			bytes_needed_d = 2'd3;
			char_total_d   = LEN_4;
			partial_char_d = {16'd0, data_s1};
		end else if (data_s1 >= LEAD3_MIN) begin
			bytes_needed_d = 2'd2;
			char_total_d   = LEN_3;
			partial_char_d = {16'd0, data_s1};
		end else if (data_s1 >= LEAD2_MIN) begin
			bytes_needed_d = 2'd1;
			char_total_d   = LEN_2;
			partial_char_d = {16'd0, data_s1};
		end else if (data_s1 >= CONT_MIN) begin
			// Stray continuation byte, skipped.
		end else begin
			res.valid  = 1'b1;
			res.bytes  = {data_s1, 24'd0};
			res.length = LEN_1;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			bytes_needed_q <= 2'd0;
			partial_char_q <= '0;
			char_total_q   <= LEN_NONE;
			dropping_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_go) begin
				bytes_needed_q <= bytes_needed_d;
				partial_char_q <= partial_char_d;
				char_total_q   <= char_total_d;
				dropping_q     <= dropping_d;
			end
			if (s1_go && res.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
		if (s1_go && res.valid) begin
			char_bytes_q  <= res.bytes;
			char_length_q <= res.length;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_bytes  = char_bytes_q;
	assign char_length = char_length_q;

`include "utf8_char_splitter_assert.svh"

	`UCS_ASSERT_NOW(a_collect_total, bytes_needed_q != 2'd0,
		(char_total_q >= LEN_2) && ({1'b0, bytes_needed_q} < char_total_q),
		"collection count exceeds character length")
	`UCS_ASSERT_NOW(a_drop_no_partial, dropping_q, bytes_needed_q == 2'd0,
		"line discard while a character is open")
	`UCS_ASSERT_NOW(a_len_range, out_valid_q,
		(char_length_q == LEN_1) || (char_length_q == LEN_2) ||
		(char_length_q == LEN_3) || (char_length_q == LEN_4),
		"result length out of range")
	`UCS_ASSERT_NOW(a_ascii_packed, out_valid_q && (char_length_q == LEN_1),
		(char_bytes_q[31] == 1'b0) && (char_bytes_q[23:0] == 24'd0),
		"single-byte result badly packed")
	`UCS_ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_go, valid_s1 && $stable(data_s1),
		"stalled input word lost")

endmodule
